// File: hw/rtl/dfir_pkg.sv
// Shared types, constants and codes for the decimating FIR filter.
`default_nettype none

package dfir_pkg;

  // Default sizing of the filter.
  localparam int DEF_MAX_TAPS    = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed field widths.
  localparam int COEF_BITS      = 16;
  localparam int VALUE_BITS     = 16;
  localparam int INDEX_BITS     = 6;
  localparam int OUT_BITS       = 38;
  localparam int DEC_BITS       = 5;
  localparam int TAPS_BITS      = 7;
  localparam int PHASE_BITS     = 4;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 8;

  // Largest decimation factor honored.
  localparam logic [DEC_BITS-1:0] DEC_MAX = DEC_BITS'(16);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DECIMATION  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TAPS_IN_USE = CFG_INDEX_BITS'(1);

  // Input opcodes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_HOLD
  } dfir_state_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;    // start a new sum
    logic rd_valid; // RAM read data for one tap is present this cycle
    logic rd_live;  // that tap holds a sample that was really pushed
  } mac_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/dfir_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module dfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/dfir_mac.sv
// Shared multiply-accumulate unit: one coefficient times one sample per cycle.
`default_nettype none

module dfir_mac #(
  parameter int SAMPLE_BITS = dfir_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire dfir_pkg::mac_ctrl_t              ctrl,
  input  wire logic [dfir_pkg::COEF_BITS-1:0]   coef_data,
  input  wire logic [SAMPLE_BITS-1:0]           hist_data,
  output logic      [dfir_pkg::OUT_BITS-1:0]    acc,
  output logic                                  busy
);

  import dfir_pkg::*;

  localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;

  logic signed [PROD_BITS-1:0] prod_r;
  logic                        prod_v_r;
  logic                        prod_live_r;
  logic        [OUT_BITS-1:0]  acc_r;

  // Product stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r    <= 1'b0;
      prod_live_r <= 1'b0;
    end else begin
      prod_v_r    <= ctrl.rd_valid;
      prod_live_r <= ctrl.rd_live;
    end
  end

  // Product register; taps beyond the pushed history count as zero.
  always_ff @(posedge clk) begin
    prod_r <= $signed(coef_data) * $signed(hist_data);
  end

  // Accumulator wraps modulo the output width.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r && prod_live_r) begin
      acc_r <= acc_r + OUT_BITS'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign busy = prod_v_r;

endmodule

`default_nettype wire

// File: hw/rtl/decimating_fir_filter.sv
// Top level of the decimating FIR filter: sequencer, delay line, coefficients.
`default_nettype none

// Each input beat either loads one Q1.15 coefficient or pushes one sample into
// a delay line of MAX_TAPS entries held in RAM. Loads and samples that produce
// no output are taken without a stall and may follow back to back. A sample that
// produces an output (the first after reset, then one every decimation samples)
// starts a sum of taps_in_use products computed by a single multiply-accumulate
// unit that reads one coefficient and one history entry per cycle; the input
// is stalled until the sum is written to the output register, which lets the
// next beats be taken while a result waits, but a new sum is not written out
// until the previous result has been taken. History starts at zero through a
// fill count, so there is no clearing pass after reset. The result is the full
// product sum, unshifted, wrapped to 38 bits.
module decimating_fir_filter #(
  parameter int MAX_TAPS    = dfir_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = dfir_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Input channel.
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_opcode,
  input  wire logic [dfir_pkg::INDEX_BITS-1:0]       in_coef_index,
  input  wire logic signed [dfir_pkg::VALUE_BITS-1:0] in_value,
  // Result channel.
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [dfir_pkg::OUT_BITS-1:0]       out_filtered,
  // Configuration channel.
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [dfir_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [dfir_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import dfir_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);
  localparam int CW = $clog2(MAX_TAPS + 1);

  dfir_state_t state_r, state_nxt;

  logic [DEC_BITS-1:0]   decimation_r;
  logic [TAPS_BITS-1:0]  taps_r;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic                  iss_r, iss_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic                  rd_v_r, rd_v_nxt;
  logic                  rd_live_r, rd_live_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0]   out_data_r;
  logic                  out_load;

  logic                  in_accept;
  logic                  push;
  logic                  load;
  logic                  fire;
  logic [AW-1:0]         wp_inc;
  logic [DEC_BITS-1:0]   dec_eff;
  logic [DEC_BITS-1:0]   phase_inc;
  logic [CW-1:0]         taps_eff;
  logic                  out_free;
  logic                  sum_done;
  logic [SAMPLE_BITS-1:0] sample;

  logic [COEF_BITS-1:0]   coef_rd;
  logic [SAMPLE_BITS-1:0] hist_rd;
  logic [OUT_BITS-1:0]    mac_acc;
  logic                   mac_busy;
  mac_ctrl_t              mac_ctrl;

  // Handshake decode.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign push      = in_accept && (in_opcode == OP_PUSH);
  assign load      = in_accept && (in_opcode == OP_LOAD) && (32'(in_coef_index) < MAX_TAPS);
  assign fire      = push && (phase_r == '0);
  assign out_free  = !out_valid_r || !out_stall;
  assign sample    = SAMPLE_BITS'(in_value);
  assign cfg_ready = 1'b1;

  // Effective register values after clamping.
  always_comb begin
    if (decimation_r == '0) begin
      dec_eff = DEC_BITS'(1);
    end else if (decimation_r > DEC_MAX) begin
      dec_eff = DEC_MAX;
    end else begin
      dec_eff = decimation_r;
    end
    if (taps_r == '0) begin
      taps_eff = CW'(1);
    end else if (32'(taps_r) > MAX_TAPS) begin
      taps_eff = CW'(MAX_TAPS);
    end else begin
      taps_eff = CW'(taps_r);
    end
  end

  assign wp_inc    = (32'(wp_r) == MAX_TAPS - 1) ? '0 : wp_r + AW'(1);
  assign phase_inc = DEC_BITS'(phase_r) + DEC_BITS'(1);
  assign sum_done  = (state_r == ST_MAC) && !iss_r && !rd_v_r && !mac_busy;

  // Sequencer: next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    iss_nxt       = iss_r;
    k_nxt         = k_r;
    ptr_nxt       = ptr_r;
    rd_v_nxt      = 1'b0;
    rd_live_nxt   = 1'b0;
    out_load      = 1'b0;
    mac_ctrl      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (push) begin
          wp_nxt    = wp_inc;
          fill_nxt  = (32'(fill_r) == MAX_TAPS) ? fill_r : fill_r + CW'(1);
          phase_nxt = (phase_inc >= dec_eff) ? '0 : phase_inc[PHASE_BITS-1:0];
        end
        if (fire) begin
          state_nxt      = ST_MAC;
          iss_nxt        = 1'b1;
          k_nxt          = '0;
          ptr_nxt        = wp_inc;
          mac_ctrl.clear = 1'b1;
        end
      end
      ST_MAC: begin
        // Issue one tap read per cycle, newest sample first.
        if (iss_r) begin
          rd_v_nxt    = 1'b1;
          rd_live_nxt = (k_r < fill_r);
          k_nxt       = k_r + CW'(1);
          ptr_nxt     = (ptr_r == '0) ? AW'(MAX_TAPS - 1) : ptr_r - AW'(1);
          if (k_r + CW'(1) == taps_eff) begin
            iss_nxt = 1'b0;
          end
        end
        if (sum_done) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    mac_ctrl.rd_valid = rd_v_r;
    mac_ctrl.rd_live  = rd_live_r;
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      iss_r       <= 1'b0;
      k_r         <= '0;
      ptr_r       <= '0;
      rd_v_r      <= 1'b0;
      rd_live_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      iss_r       <= iss_nxt;
      k_r         <= k_nxt;
      ptr_r       <= ptr_nxt;
      rd_v_r      <= rd_v_nxt;
      rd_live_r   <= rd_live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimation_r <= DEC_BITS'(1);
      taps_r       <= TAPS_BITS'(64);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DECIMATION) begin
        decimation_r <= cfg_data[DEC_BITS-1:0];
      end else if (cfg_index == CFG_TAPS_IN_USE) begin
        taps_r <= cfg_data[TAPS_BITS-1:0];
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= mac_acc;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = $signed(out_data_r);

  // Delay line, written as a circular buffer.
  dfir_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_TAPS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (wp_inc),
    .wr_data (sample),
    .rd_addr (ptr_r),
    .rd_data (hist_rd)
  );

  // Coefficient store.
  dfir_ram #(
    .WIDTH(COEF_BITS),
    .DEPTH(MAX_TAPS)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (load),
    .wr_addr (AW'(in_coef_index)),
    .wr_data (in_value),
    .rd_addr (k_r[AW-1:0]),
    .rd_data (coef_rd)
  );

  // Shared multiply-accumulate unit.
  dfir_mac #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mac_ctrl),
    .coef_data (coef_rd),
    .hist_data (hist_rd),
    .acc       (mac_acc),
    .busy      (mac_busy)
  );

  // A new result appears only at the end of a sum.
  a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_MAC || state_r == ST_HOLD))
    else $error("result raised without a finished sum");

  // The tap counter never runs past the taps in use.
  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r |-> (k_r < taps_eff))
    else $error("tap counter beyond taps in use");

  // Waiting for the output only happens while a result is pending.
  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("holding a sum with the output register empty");

  // The history fill count saturates at the delay line depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= MAX_TAPS)
    else $error("history fill count beyond depth");

endmodule

`default_nettype wire

// File: sim/dfir_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the decimating FIR filter: predicts each output sum and compares it.

module dfir_checker (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  input  wire logic                                   in_stall,
  input  wire logic                                   in_opcode,
  input  wire logic [dfir_pkg::INDEX_BITS-1:0]        in_coef_index,
  input  wire logic signed [dfir_pkg::VALUE_BITS-1:0] in_value,
  input  wire logic                                   out_valid,
  input  wire logic                                   out_stall,
  input  wire logic signed [dfir_pkg::OUT_BITS-1:0]   out_filtered,
  input  wire logic                                   cfg_valid,
  input  wire logic                                   cfg_ready,
  input  wire logic [dfir_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [dfir_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output int                                          fail_count,
  output int                                          pending
);

  import dfir_pkg::*;

  localparam int TAPS = DEF_MAX_TAPS;

  // Shadow copy of the filter state and its registers.
  logic [DEC_BITS-1:0]           decimation;
  logic [TAPS_BITS-1:0]          taps_in_use;
  logic [PHASE_BITS-1:0]         phase;
  logic signed [VALUE_BITS-1:0]  delay_line [TAPS];
  logic signed [COEF_BITS-1:0]   coefs [TAPS];
  logic signed [OUT_BITS-1:0]    expected_sums [$];
  logic signed [OUT_BITS-1:0]    next_sum;

  // Full-precision dot product of coefficients and delay line, wrapped to the output width.
  function automatic logic signed [OUT_BITS-1:0] tap_sum();
    longint acc;
    int n;
    acc = 0;
    n = (taps_in_use == 0) ? 1 : (taps_in_use > TAPS) ? TAPS : int'(taps_in_use);
    for (int k = 0; k < n; k++) begin
      acc += longint'(coefs[k]) * longint'(delay_line[k]);
    end
    return acc[OUT_BITS-1:0];
  endfunction

  // Shift one sample into the delay line; the phase counter decides whether a sum is due.
  task automatic shift_in_sample(input logic signed [VALUE_BITS-1:0] sample);
    logic fires;
    int dec;
    fires = (phase == '0);
    dec = (decimation == 0) ? 1 : (decimation > DEC_MAX) ? int'(DEC_MAX) : int'(decimation);
    for (int k = TAPS - 1; k > 0; k--) begin
      delay_line[k] = delay_line[k-1];
    end
    delay_line[0] = sample;
    // A lowered decimation wraps the counter as soon as it reaches the new limit.
    phase = (int'(phase) + 1 >= dec) ? '0 : phase + 1'b1;
    if (fires) begin
      expected_sums.push_back(tap_sum());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      decimation  = DEC_BITS'(1);
      taps_in_use = TAPS_BITS'(TAPS);
      phase       = '0;
      for (int k = 0; k < TAPS; k++) begin
        delay_line[k] = '0;
        coefs[k]      = '0;
      end
      expected_sums.delete();
      fail_count = 0;
    end else begin
      // Outputs are checked first, so a beat accepted on the same edge cannot be matched.
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          $error("filtered: no result expected, actual %0d", out_filtered);
          fail_count++;
        end else begin
          next_sum = expected_sums.pop_front();
          if (out_filtered !== next_sum) begin
            $error("filtered: expected %0d, actual %0d", next_sum, out_filtered);
            fail_count++;
          end
        end
      end

      // Register writes; unknown indexes are ignored.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DECIMATION) begin
          decimation = cfg_data[DEC_BITS-1:0];
        end else if (cfg_index == CFG_TAPS_IN_USE) begin
          taps_in_use = cfg_data[TAPS_BITS-1:0];
        end
      end

      // Input beats: a load touches only the coefficient slot.
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_LOAD) begin
          coefs[in_coef_index] = in_value;
        end else begin
          shift_in_sample(in_value);
        end
      end
    end
    pending = expected_sums.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the decimating FIR filter testbench: clock, reset, stimulus and verdict.

module testbench;
  import dfir_pkg::*;

  localparam int DRAIN_CYCLES = DEF_MAX_TAPS + 16;
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 16'sh7FFF;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_FIRST = CFG_TAPS_IN_USE + 1'b1;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_opcode;
  logic [INDEX_BITS-1:0]        in_coef_index;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [OUT_BITS-1:0]   out_filtered;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_INDEX_BITS-1:0]    cfg_index;
  logic [CFG_DATA_BITS-1:0]     cfg_data;
  int                           fail_count;
  int                           pending;
  bit                           no_gaps;

  decimating_fir_filter dut (.*);

  dfir_checker fir_monitor (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Sample or coefficient value biased toward the extremes and toward zero.
  function automatic logic signed [VALUE_BITS-1:0] rand_value();
    int r;
    r = $urandom_range(99);
    if (r < 15) return VAL_MIN;
    if (r < 30) return VAL_MAX;
    if (r < 40) return VALUE_BITS'($urandom_range(4) - 2);
    return VALUE_BITS'($urandom);
  endfunction

  // Result side: stall for random stretches, with long quiet runs in between.
  initial begin
    int run;
    int hold;
    out_stall <= 1'b0;
    forever begin
      run = ($urandom_range(19) == 0) ? $urandom_range(300, 100) : 1 + pick_gap();
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Drive one input beat and hold it until it is taken.
  task automatic send_beat(input logic op, input logic [INDEX_BITS-1:0] idx,
                           input logic signed [VALUE_BITS-1:0] val);
    int gap;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_coef_index <= idx;
    in_value      <= val;
    do @(posedge clk); while (in_stall);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One register write; valid stays up between writes of a group.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) begin
      cfg_valid <= 1'b0;
    end
  endtask

  // Let every expected sum come out, then give a pending sum time to finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // New register setting followed by a run of random loads and samples.
  task automatic random_phase(input int beats);
    logic [CFG_INDEX_BITS-1:0] widx [3];
    logic [CFG_DATA_BITS-1:0]  wdat [3];
    int nw;
    int r;
    settle();
    no_gaps = ($urandom_range(3) == 0);
    nw = 0;
    r = $urandom_range(3);
    if (r != 1) begin
      widx[nw] = CFG_DECIMATION;
      case ($urandom_range(5))
        0: wdat[nw] = 8'd1;
        1: wdat[nw] = 8'd16;
        2: wdat[nw] = CFG_DATA_BITS'($urandom_range(255));
        default: wdat[nw] = CFG_DATA_BITS'($urandom_range(16, 1));
      endcase
      nw++;
    end
    if (r != 0) begin
      widx[nw] = CFG_TAPS_IN_USE;
      case ($urandom_range(5))
        0: wdat[nw] = 8'd1;
        1: wdat[nw] = 8'd64;
        2: wdat[nw] = CFG_DATA_BITS'($urandom_range(255));
        default: wdat[nw] = CFG_DATA_BITS'($urandom_range(64, 1));
      endcase
      nw++;
    end
    // Now and then a write to an index with no register behind it.
    if ($urandom_range(4) == 0) begin
      widx[nw] = CFG_INDEX_BITS'($urandom_range(255, int'(CFG_SPARE_FIRST)));
      wdat[nw] = CFG_DATA_BITS'($urandom_range(255));
      nw++;
    end
    for (int i = 0; i < nw; i++) begin
      write_reg(widx[i], wdat[i], i == nw - 1);
    end
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(4) == 0) begin
        send_beat(OP_LOAD, INDEX_BITS'($urandom_range(63)), rand_value());
      end else begin
        send_beat(OP_PUSH, INDEX_BITS'($urandom_range(63)), rand_value());
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_PUSH;
    in_coef_index <= '0;
    in_value      <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    no_gaps        = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Four taps, one output per sample: extremes against an empty history.
    write_reg(CFG_TAPS_IN_USE, 8'd4, 1'b1);
    send_beat(OP_LOAD, 6'd0, VAL_MIN);
    send_beat(OP_LOAD, 6'd1, VAL_MAX);
    send_beat(OP_LOAD, 6'd2, -16'sd1);
    send_beat(OP_LOAD, 6'd3, 16'sd1);
    send_beat(OP_LOAD, 6'd63, 16'sh5555);
    send_beat(OP_PUSH, 6'd63, VAL_MAX);
    send_beat(OP_PUSH, 6'd0, VAL_MIN);
    // A load between samples must not disturb the history or the phase.
    send_beat(OP_LOAD, 6'd1, 16'sd0);
    send_beat(OP_PUSH, 6'd42, -16'sd1);
    send_beat(OP_PUSH, 6'd21, 16'sd0);
    send_beat(OP_PUSH, 6'd7, 16'sd1);
    send_beat(OP_PUSH, 6'd0, VAL_MIN);
    send_beat(OP_PUSH, 6'd63, VAL_MAX);

    // Zero in both registers acts as one; fill every coefficient slot.
    settle();
    write_reg(CFG_DECIMATION, 8'd0, 1'b0);
    write_reg(CFG_TAPS_IN_USE, 8'd0, 1'b1);
    for (int k = 0; k < DEF_MAX_TAPS; k++) begin
      send_beat(OP_LOAD, INDEX_BITS'(k), VAL_MIN);
    end
    send_beat(OP_PUSH, 6'd5, VAL_MIN);
    send_beat(OP_PUSH, 6'd9, VAL_MAX);
    send_beat(OP_PUSH, 6'd0, -16'sd1);

    // Oversized settings clamp to sixteen and all taps; reach the largest sum.
    settle();
    write_reg(CFG_DECIMATION, 8'hF1, 1'b0);
    write_reg(CFG_TAPS_IN_USE, 8'hFF, 1'b1);
    repeat (DEF_MAX_TAPS + 2) begin
      send_beat(OP_PUSH, INDEX_BITS'($urandom_range(63)), VAL_MIN);
    end

    repeat (9) begin
      random_phase($urandom_range(45, 25));
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/dfir_pkg.sv
hw/rtl/dfir_ram.sv
hw/rtl/dfir_mac.sv
hw/rtl/decimating_fir_filter.sv
sim/dfir_checker.sv
sim/testbench.sv
